// ===== sv/cvkt_pkg.sv =====
// Package: shared types, constants and the microcode store of the Kalman tracker.
package cvkt_pkg;

  localparam int FRAC_BITS = 16;
  localparam int W         = 32;
  localparam int DIV_W     = W + FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);
  localparam int NAXES     = 3;
  localparam int RF_DEPTH  = 64;
  localparam int RF_AW     = $clog2(RF_DEPTH);
  localparam int PC_W      = 7;
  localparam int CFG_IDX_W = 3;

  localparam longint ONE_Q = 64'sd1 <<< FRAC_BITS;

  localparam logic [30:0] Q_POS_RST    = 31'((ONE_Q + 5) / 10);
  localparam logic [30:0] Q_VEL_RST    = 31'((ONE_Q + 10) / 20);
  localparam logic [30:0] R_POS_RST    = 31'((ONE_Q + 5) / 10);
  localparam logic [30:0] R_VEL_RST    = 31'(ONE_Q);
  localparam logic [30:0] P0_POS_RST   = 31'(ONE_Q);
  localparam logic [30:0] P0_VEL_RST   = 31'(ONE_Q);
  localparam logic [31:0] P0_CROSS_RST = 32'((6 * ONE_Q + 5) / 10);

  localparam logic [W-1:0] I32_MAX = 32'h7fff_ffff;
  localparam logic [W-1:0] I32_MIN = 32'h8000_0000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_Q_POS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Q_VEL    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_R_POS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_R_VEL    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_P0_POS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_P0_VEL   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_P0_CROSS = 3'd6;

  // input commands
  localparam logic [1:0] CMD_MEAS       = 2'd0;
  localparam logic [1:0] CMD_PRED_TS    = 2'd1;
  localparam logic [1:0] CMD_PRED_DELTA = 2'd2;

  // result status
  localparam logic [1:0] STAT_INIT = 2'd0;
  localparam logic [1:0] STAT_UPD  = 2'd1;
  localparam logic [1:0] STAT_SING = 2'd2;
  localparam logic [1:0] STAT_PRED = 2'd3;

  // micro-ops
  localparam logic [3:0] OP_NOP  = 4'd0;
  localparam logic [3:0] OP_MEAS = 4'd1;
  localparam logic [3:0] OP_DT   = 4'd2;
  localparam logic [3:0] OP_SETT = 4'd3;
  localparam logic [3:0] OP_ZERO = 4'd4;
  localparam logic [3:0] OP_CFG  = 4'd5;
  localparam logic [3:0] OP_MOV  = 4'd6;
  localparam logic [3:0] OP_ADD  = 4'd7;
  localparam logic [3:0] OP_SUB  = 4'd8;
  localparam logic [3:0] OP_DET  = 4'd9;
  localparam logic [3:0] OP_MUL  = 4'd10;
  localparam logic [3:0] OP_DIV  = 4'd11;
  localparam logic [3:0] OP_OUTP = 4'd12;
  localparam logic [3:0] OP_OUTV = 4'd13;

  // operand slots: L* are per axis, G* shared
  localparam logic [4:0] L0 = 5'd0,  L1 = 5'd1,  L2 = 5'd2,  L3 = 5'd3;
  localparam logic [4:0] L4 = 5'd4,  L5 = 5'd5,  L6 = 5'd6,  L7 = 5'd7;
  localparam logic [4:0] L8 = 5'd8,  L9 = 5'd9,  L10 = 5'd10, L11 = 5'd11;
  localparam logic [4:0] L12 = 5'd12, L13 = 5'd13, L14 = 5'd14, L15 = 5'd15;
  localparam logic [4:0] G_DT = 5'd16, G_QPOS = 5'd17, G_QVEL = 5'd18;
  localparam logic [4:0] G_RPOS = 5'd19, G_RVEL = 5'd20;
  localparam logic [4:0] XX = 5'd0;

  // segment entry points
  localparam logic [PC_W-1:0] SEG_INIT = 7'd0;
  localparam logic [PC_W-1:0] SEG_UPD0 = 7'd8;
  localparam logic [PC_W-1:0] SEG_UPD1 = 7'd14;
  localparam logic [PC_W-1:0] SEG_CORR = 7'd33;
  localparam logic [PC_W-1:0] SEG_SING = 7'd77;
  localparam logic [PC_W-1:0] SEG_PRE0 = 7'd83;
  localparam logic [PC_W-1:0] SEG_PRED = 7'd84;
  localparam logic [PC_W-1:0] SEG_ZOUT = 7'd88;

  typedef struct packed {
    logic [3:0] op;
    logic [4:0] dst;
    logic [4:0] sa;
    logic [4:0] sb;
    logic       last;
  } uinst_t;

  typedef struct packed {
    logic       load;
    logic       exec;
    logic       mul_wr;
    logic       div_wr;
    logic       publish;
    logic [1:0] status;
    logic [1:0] axis;
    uinst_t     ui;
  } ctl_t;

  typedef struct packed {
    logic div_done;
    logic singular;
  } sts_t;

  function automatic uinst_t mk(input logic [3:0] op, input logic [4:0] dst,
                                input logic [4:0] sa, input logic [4:0] sb,
                                input logic last);
    uinst_t u;
    u.op = op;
    u.dst = dst;
    u.sa = sa;
    u.sb = sb;
    u.last = last;
    return u;
  endfunction

  function automatic logic [4:0] cfg_slot(input logic [CFG_IDX_W-1:0] idx);
    return 5'(idx);
  endfunction

  function automatic uinst_t urom(input logic [PC_W-1:0] pc);
    uinst_t u;
    case (pc)
      // first measurement
      7'd0:  u = mk(OP_MEAS, L0, XX, XX, 1'b0);
      7'd1:  u = mk(OP_ZERO, L1, XX, XX, 1'b0);
      7'd2:  u = mk(OP_CFG, L2, cfg_slot(CFG_P0_POS), XX, 1'b0);
      7'd3:  u = mk(OP_CFG, L3, cfg_slot(CFG_P0_CROSS), XX, 1'b0);
      7'd4:  u = mk(OP_CFG, L4, cfg_slot(CFG_P0_VEL), XX, 1'b0);
      7'd5:  u = mk(OP_OUTP, XX, L0, XX, 1'b0);
      7'd6:  u = mk(OP_OUTV, XX, L1, XX, 1'b0);
      7'd7:  u = mk(OP_SETT, XX, XX, XX, 1'b1);
      // update, shared setup
      7'd8:  u = mk(OP_DT, G_DT, XX, XX, 1'b0);
      7'd9:  u = mk(OP_SETT, XX, XX, XX, 1'b0);
      7'd10: u = mk(OP_CFG, G_QPOS, cfg_slot(CFG_Q_POS), XX, 1'b0);
      7'd11: u = mk(OP_CFG, G_QVEL, cfg_slot(CFG_Q_VEL), XX, 1'b0);
      7'd12: u = mk(OP_CFG, G_RPOS, cfg_slot(CFG_R_POS), XX, 1'b0);
      7'd13: u = mk(OP_CFG, G_RVEL, cfg_slot(CFG_R_VEL), XX, 1'b1);
      // update, predict and innovation per axis
      7'd14: u = mk(OP_MEAS, L5, XX, XX, 1'b0);
      7'd15: u = mk(OP_SUB, L8, L5, L0, 1'b0);
      7'd16: u = mk(OP_DIV, L6, L8, G_DT, 1'b0);
      7'd17: u = mk(OP_MUL, L8, G_DT, L1, 1'b0);
      7'd18: u = mk(OP_ADD, L7, L0, L8, 1'b0);
      7'd19: u = mk(OP_MUL, L8, G_DT, L4, 1'b0);
      7'd20: u = mk(OP_ADD, L9, L3, L8, 1'b0);
      7'd21: u = mk(OP_MUL, L8, G_DT, L3, 1'b0);
      7'd22: u = mk(OP_ADD, L10, L2, L8, 1'b0);
      7'd23: u = mk(OP_MUL, L8, G_DT, L9, 1'b0);
      7'd24: u = mk(OP_ADD, L10, L10, L8, 1'b0);
      7'd25: u = mk(OP_ADD, L10, L10, G_QPOS, 1'b0);
      7'd26: u = mk(OP_ADD, L11, L4, G_QVEL, 1'b0);
      7'd27: u = mk(OP_ADD, L12, L10, G_RPOS, 1'b0);
      7'd28: u = mk(OP_ADD, L13, L11, G_RVEL, 1'b0);
      7'd29: u = mk(OP_MUL, L8, L12, L13, 1'b0);
      7'd30: u = mk(OP_MUL, L15, L9, L9, 1'b0);
      7'd31: u = mk(OP_DET, L14, L8, L15, 1'b0);
      7'd32: u = mk(OP_NOP, XX, XX, XX, 1'b1);
      // correction per axis
      7'd33: u = mk(OP_SUB, L5, L5, L7, 1'b0);
      7'd34: u = mk(OP_SUB, L6, L6, L1, 1'b0);
      7'd35: u = mk(OP_MUL, L8, L10, L13, 1'b0);
      7'd36: u = mk(OP_MUL, L15, L9, L9, 1'b0);
      7'd37: u = mk(OP_SUB, L8, L8, L15, 1'b0);
      7'd38: u = mk(OP_DIV, L0, L8, L14, 1'b0);
      7'd39: u = mk(OP_MUL, L8, L9, L12, 1'b0);
      7'd40: u = mk(OP_MUL, L15, L10, L9, 1'b0);
      7'd41: u = mk(OP_SUB, L8, L8, L15, 1'b0);
      7'd42: u = mk(OP_DIV, L2, L8, L14, 1'b0);
      7'd43: u = mk(OP_MUL, L8, L9, L13, 1'b0);
      7'd44: u = mk(OP_MUL, L15, L11, L9, 1'b0);
      7'd45: u = mk(OP_SUB, L8, L8, L15, 1'b0);
      7'd46: u = mk(OP_DIV, L3, L8, L14, 1'b0);
      7'd47: u = mk(OP_MUL, L8, L11, L12, 1'b0);
      7'd48: u = mk(OP_MUL, L15, L9, L9, 1'b0);
      7'd49: u = mk(OP_SUB, L8, L8, L15, 1'b0);
      7'd50: u = mk(OP_DIV, L4, L8, L14, 1'b0);
      7'd51: u = mk(OP_MUL, L8, L0, L5, 1'b0);
      7'd52: u = mk(OP_MUL, L15, L2, L6, 1'b0);
      7'd53: u = mk(OP_ADD, L8, L8, L15, 1'b0);
      7'd54: u = mk(OP_ADD, L7, L7, L8, 1'b0);
      7'd55: u = mk(OP_MUL, L8, L3, L5, 1'b0);
      7'd56: u = mk(OP_MUL, L15, L4, L6, 1'b0);
      7'd57: u = mk(OP_ADD, L8, L8, L15, 1'b0);
      7'd58: u = mk(OP_ADD, L1, L1, L8, 1'b0);
      7'd59: u = mk(OP_MUL, L8, L0, L10, 1'b0);
      7'd60: u = mk(OP_MUL, L15, L2, L9, 1'b0);
      7'd61: u = mk(OP_ADD, L8, L8, L15, 1'b0);
      7'd62: u = mk(OP_SUB, L12, L10, L8, 1'b0);
      7'd63: u = mk(OP_MUL, L8, L0, L9, 1'b0);
      7'd64: u = mk(OP_MUL, L15, L2, L11, 1'b0);
      7'd65: u = mk(OP_ADD, L8, L8, L15, 1'b0);
      7'd66: u = mk(OP_SUB, L13, L9, L8, 1'b0);
      7'd67: u = mk(OP_MUL, L8, L3, L9, 1'b0);
      7'd68: u = mk(OP_MUL, L15, L4, L11, 1'b0);
      7'd69: u = mk(OP_ADD, L8, L8, L15, 1'b0);
      7'd70: u = mk(OP_SUB, L14, L11, L8, 1'b0);
      7'd71: u = mk(OP_MOV, L0, L7, XX, 1'b0);
      7'd72: u = mk(OP_MOV, L2, L12, XX, 1'b0);
      7'd73: u = mk(OP_MOV, L3, L13, XX, 1'b0);
      7'd74: u = mk(OP_MOV, L4, L14, XX, 1'b0);
      7'd75: u = mk(OP_OUTP, XX, L0, XX, 1'b0);
      7'd76: u = mk(OP_OUTV, XX, L1, XX, 1'b1);
      // singular innovation: keep the prediction
      7'd77: u = mk(OP_MOV, L0, L7, XX, 1'b0);
      7'd78: u = mk(OP_MOV, L2, L10, XX, 1'b0);
      7'd79: u = mk(OP_MOV, L3, L9, XX, 1'b0);
      7'd80: u = mk(OP_MOV, L4, L11, XX, 1'b0);
      7'd81: u = mk(OP_OUTP, XX, L7, XX, 1'b0);
      7'd82: u = mk(OP_OUTV, XX, L1, XX, 1'b1);
      // prediction query
      7'd83: u = mk(OP_DT, G_DT, XX, XX, 1'b1);
      7'd84: u = mk(OP_MUL, L8, G_DT, L1, 1'b0);
      7'd85: u = mk(OP_ADD, L15, L0, L8, 1'b0);
      7'd86: u = mk(OP_OUTP, XX, L15, XX, 1'b0);
      7'd87: u = mk(OP_OUTV, XX, L1, XX, 1'b1);
      // prediction before the track exists
      7'd88: u = mk(OP_ZERO, L8, XX, XX, 1'b0);
      7'd89: u = mk(OP_OUTP, XX, L8, XX, 1'b0);
      7'd90: u = mk(OP_OUTV, XX, L8, XX, 1'b1);
      default: u = mk(OP_NOP, XX, XX, XX, 1'b1);
    endcase
    return u;
  endfunction

endpackage

// ===== sv/cvkt_ram.sv =====
// Generic two-read, one-write RAM with registered read data.
module cvkt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== sv/cvkt_div.sv =====
// Fixed-point divider: (num << FRAC_BITS) / den, one quotient bit per cycle, saturating.
module cvkt_div
  import cvkt_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic         done,
  output logic [W-1:0] quo,
  output logic         clip
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [W-1:0]         rem;
  logic [DIV_W-1:0]     sh;
  logic [W-1:0]         dm;
  logic                 neg;
  logic                 num_neg;
  logic                 num_zero;
  logic                 den_zero;

  logic [W-1:0] nm;
  logic [W:0]   trial;
  logic         ge;

  assign nm    = num[W-1] ? (~num + 1'b1) : num;
  assign trial = {rem, sh[DIV_W-1]};
  assign ge    = trial >= {1'b0, dm};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= DIV_CNT_W'(DIV_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh       <= DIV_W'(nm) << FRAC_BITS;
      rem      <= '0;
      dm       <= den[W-1] ? (~den + 1'b1) : den;
      neg      <= num[W-1] ^ den[W-1];
      num_neg  <= num[W-1];
      num_zero <= (num == '0);
      den_zero <= (den == '0);
    end else if (busy) begin
      rem <= ge ? W'(trial - {1'b0, dm}) : trial[W-1:0];
      sh  <= {sh[DIV_W-2:0], ge};
    end
  end

  always_comb begin
    quo  = sh[W-1:0];
    clip = 1'b0;
    if (den_zero) begin
      clip = 1'b1;
      quo  = num_zero ? '0 : (num_neg ? I32_MIN : I32_MAX);
    end else if (neg) begin
      if ((|sh[DIV_W-1:W]) || (sh[W-1] && (|sh[W-2:0]))) begin
        clip = 1'b1;
        quo  = I32_MIN;
      end else begin
        quo = ~sh[W-1:0] + 1'b1;
      end
    end else if (|sh[DIV_W-1:W-1]) begin
      clip = 1'b1;
      quo  = I32_MAX;
    end
  end

endmodule

// ===== sv/cvkt_datapath.sv =====
// Datapath: slot RAM, saturating adder, multiplier, divider, config and output registers.
module cvkt_datapath
  import cvkt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  ctl_t                 ctl,
  output sts_t                 sts,
  input  logic [1:0]           cmd,
  input  logic [W-1:0]         meas_x,
  input  logic [W-1:0]         meas_y,
  input  logic [W-1:0]         meas_z,
  input  logic [W-1:0]         time_or_delta,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [W-1:0]         cfg_data,
  output logic [W-1:0]         pos_x,
  output logic [W-1:0]         pos_y,
  output logic [W-1:0]         pos_z,
  output logic [W-1:0]         vel_x,
  output logic [W-1:0]         vel_y,
  output logic [W-1:0]         vel_z,
  output logic [1:0]           status,
  output logic                 clipped
);

  logic [30:0] q_pos, q_vel, r_pos, r_vel, p0_pos, p0_vel;
  logic [W-1:0] p0_cross;
  logic [W-1:0] last_time;
  logic [W-1:0] meas_r [NAXES];
  logic [W-1:0] t_r;
  logic [1:0]   cmd_r;
  logic [W-1:0] res_pos [NAXES];
  logic [W-1:0] res_vel [NAXES];
  logic         clip;
  logic         singular;
  logic signed [2*W-1:0] prod;

  logic [RF_AW-1:0] raddr_a, raddr_b, waddr;
  logic [W-1:0]     opa, opb, wdata;
  logic             we;

  logic [W:0]   add33, sub33, sel33;
  logic [W-1:0] alu_res;
  logic         alu_ovf;
  logic [W-1:0] cfg_val;
  logic [W-1:0] dt_val;
  logic         dt_clip;
  logic signed [2*W-1:0] mul_rnd, mul_sh;
  logic [W-1:0] mul_res;
  logic         mul_ovf;
  logic         div_start, div_done, div_clip;
  logic [W-1:0] div_quo;

  function automatic logic [RF_AW-1:0] slot_addr(input logic [4:0] f, input logic [1:0] axis);
    return f[4] ? {2'b11, f[3:0]} : {axis, f[3:0]};
  endfunction

  assign raddr_a = slot_addr(ctl.ui.sa, ctl.axis);
  assign raddr_b = slot_addr(ctl.ui.sb, ctl.axis);
  assign waddr   = slot_addr(ctl.ui.dst, ctl.axis);

  cvkt_ram #(.WIDTH(W), .DEPTH(RF_DEPTH)) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (opa),
    .rdata_b (opb)
  );

  assign div_start = ctl.exec && (ctl.ui.op == OP_DIV);

  cvkt_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (opa),
    .den   (opb),
    .done  (div_done),
    .quo   (div_quo),
    .clip  (div_clip)
  );

  assign sts.div_done = div_done;
  assign sts.singular = singular;

  // saturating add / subtract
  always_comb begin
    add33 = {opa[W-1], opa} + {opb[W-1], opb};
    sub33 = {opa[W-1], opa} - {opb[W-1], opb};
    sel33 = (ctl.ui.op == OP_ADD) ? add33 : sub33;
    alu_ovf = sel33[W] ^ sel33[W-1];
    alu_res = alu_ovf ? (sel33[W] ? I32_MIN : I32_MAX) : sel33[W-1:0];
  end

  // round half up, floor shift, saturate
  always_comb begin
    mul_rnd = prod + (64'sd1 <<< (FRAC_BITS - 1));
    mul_sh  = mul_rnd >>> FRAC_BITS;
    mul_ovf = !((&mul_sh[2*W-1:W-1]) || !(|mul_sh[2*W-1:W-1]));
    mul_res = mul_ovf ? (mul_sh[2*W-1] ? I32_MIN : I32_MAX) : mul_sh[W-1:0];
  end

  always_comb begin
    case (ctl.ui.sa[CFG_IDX_W-1:0])
      CFG_Q_POS:    cfg_val = {1'b0, q_pos};
      CFG_Q_VEL:    cfg_val = {1'b0, q_vel};
      CFG_R_POS:    cfg_val = {1'b0, r_pos};
      CFG_R_VEL:    cfg_val = {1'b0, r_vel};
      CFG_P0_POS:   cfg_val = {1'b0, p0_pos};
      CFG_P0_VEL:   cfg_val = {1'b0, p0_vel};
      CFG_P0_CROSS: cfg_val = p0_cross;
      default:      cfg_val = '0;
    endcase
  end

  // time step: timer difference wraps; a delta above the signed max saturates
  always_comb begin
    dt_clip = 1'b0;
    case (cmd_r)
      CMD_MEAS, CMD_PRED_TS: dt_val = t_r - last_time;
      CMD_PRED_DELTA: begin
        dt_clip = t_r[W-1];
        dt_val  = t_r[W-1] ? I32_MAX : t_r;
      end
      default: dt_val = '0;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    wdata = alu_res;
    if (ctl.mul_wr) begin
      we    = 1'b1;
      wdata = mul_res;
    end else if (ctl.div_wr) begin
      we    = 1'b1;
      wdata = div_quo;
    end else if (ctl.exec) begin
      case (ctl.ui.op)
        OP_MEAS: begin
          we    = 1'b1;
          wdata = meas_r[ctl.axis];
        end
        OP_DT: begin
          we    = 1'b1;
          wdata = dt_val;
        end
        OP_ZERO: begin
          we    = 1'b1;
          wdata = '0;
        end
        OP_CFG: begin
          we    = 1'b1;
          wdata = cfg_val;
        end
        OP_MOV: begin
          we    = 1'b1;
          wdata = opa;
        end
        OP_ADD, OP_SUB, OP_DET: begin
          we    = 1'b1;
          wdata = alu_res;
        end
        default: we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_pos     <= Q_POS_RST;
      q_vel     <= Q_VEL_RST;
      r_pos     <= R_POS_RST;
      r_vel     <= R_VEL_RST;
      p0_pos    <= P0_POS_RST;
      p0_vel    <= P0_VEL_RST;
      p0_cross  <= P0_CROSS_RST;
      last_time <= '0;
      clip      <= 1'b0;
      singular  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_Q_POS:    q_pos    <= cfg_data[30:0];
          CFG_Q_VEL:    q_vel    <= cfg_data[30:0];
          CFG_R_POS:    r_pos    <= cfg_data[30:0];
          CFG_R_VEL:    r_vel    <= cfg_data[30:0];
          CFG_P0_POS:   p0_pos   <= cfg_data[30:0];
          CFG_P0_VEL:   p0_vel   <= cfg_data[30:0];
          CFG_P0_CROSS: p0_cross <= cfg_data;
          default: ;
        endcase
      end
      if (ctl.exec && ctl.ui.op == OP_SETT) begin
        last_time <= t_r;
      end
      if (ctl.load) begin
        clip     <= 1'b0;
        singular <= 1'b0;
      end else begin
        if (ctl.mul_wr && mul_ovf) clip <= 1'b1;
        if (ctl.div_wr && div_clip) clip <= 1'b1;
        if (ctl.exec) begin
          case (ctl.ui.op)
            OP_ADD, OP_SUB: if (alu_ovf) clip <= 1'b1;
            OP_DET: begin
              if (alu_ovf) clip <= 1'b1;
              if (alu_res == '0) singular <= 1'b1;
            end
            OP_DT: if (dt_clip) clip <= 1'b1;
            default: ;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      meas_r[0] <= meas_x;
      meas_r[1] <= meas_y;
      meas_r[2] <= meas_z;
      t_r       <= time_or_delta;
      cmd_r     <= cmd;
    end
    if (ctl.exec && ctl.ui.op == OP_MUL) begin
      prod <= $signed(opa) * $signed(opb);
    end
    if (ctl.exec && ctl.ui.op == OP_OUTP) res_pos[ctl.axis] <= opa;
    if (ctl.exec && ctl.ui.op == OP_OUTV) res_vel[ctl.axis] <= opa;
    if (ctl.publish) begin
      pos_x   <= res_pos[0];
      pos_y   <= res_pos[1];
      pos_z   <= res_pos[2];
      vel_x   <= res_vel[0];
      vel_y   <= res_vel[1];
      vel_z   <= res_vel[2];
      status  <= ctl.status;
      clipped <= clip;
    end
  end

endmodule

// ===== sv/cvkt_ctrl.sv =====
// Controller: sequences micro-ops over the axes, chooses program segments, runs handshakes.
module cvkt_ctrl
  import cvkt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] cmd,
  output logic       out_valid,
  input  logic       out_stall,
  output ctl_t       ctl,
  input  sts_t       sts
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_MULW  = 3'd3;
  localparam logic [2:0] S_DIVW  = 3'd4;
  localparam logic [2:0] S_PUB   = 3'd5;

  localparam logic [2:0] PH_INIT = 3'd0;
  localparam logic [2:0] PH_UPD0 = 3'd1;
  localparam logic [2:0] PH_UPD1 = 3'd2;
  localparam logic [2:0] PH_FIX  = 3'd3;
  localparam logic [2:0] PH_PRE0 = 3'd4;
  localparam logic [2:0] PH_PRED = 3'd5;

  logic [2:0]      state, state_next;
  logic [2:0]      ph, ph_next;
  logic [PC_W-1:0] pc, pc_next;
  logic [PC_W-1:0] seg, seg_next;
  logic [1:0]      axis, axis_next;
  logic [1:0]      stat, stat_next;
  logic            initialized, initialized_next;
  logic            out_valid_next;
  logic            done_instr;
  logic            once;
  logic            load;
  logic            publish;
  uinst_t          ui;

  assign ui       = urom(pc);
  assign in_stall = (state != S_IDLE);
  assign load     = in_valid && (state == S_IDLE);
  assign once     = (ph == PH_UPD0) || (ph == PH_PRE0);
  assign publish  = (state == S_PUB) && (!out_valid || !out_stall);

  always_comb begin
    done_instr = 1'b0;
    case (state)
      S_EXEC:  done_instr = (ui.op != OP_MUL) && (ui.op != OP_DIV);
      S_MULW:  done_instr = 1'b1;
      S_DIVW:  done_instr = sts.div_done;
      default: done_instr = 1'b0;
    endcase
  end

  always_comb begin
    state_next       = state;
    ph_next          = ph;
    pc_next          = pc;
    seg_next         = seg;
    axis_next        = axis;
    stat_next        = stat;
    initialized_next = initialized;

    case (state)
      S_IDLE: begin
        if (load) begin
          state_next = S_FETCH;
          axis_next  = '0;
          if (cmd != CMD_MEAS) begin
            ph_next = PH_PRE0;
            seg_next = SEG_PRE0;
          end else if (initialized) begin
            ph_next = PH_UPD0;
            seg_next = SEG_UPD0;
          end else begin
            ph_next = PH_INIT;
            seg_next = SEG_INIT;
          end
          pc_next = seg_next;
        end
      end
      S_FETCH: state_next = S_EXEC;
      S_EXEC: begin
        if (ui.op == OP_MUL) state_next = S_MULW;
        else if (ui.op == OP_DIV) state_next = S_DIVW;
      end
      S_PUB: if (publish) state_next = S_IDLE;
      default: ;
    endcase

    if (done_instr) begin
      state_next = S_FETCH;
      if (!ui.last) begin
        pc_next = pc + 1'b1;
      end else if (!once && axis != 2'(NAXES - 1)) begin
        axis_next = axis + 1'b1;
        pc_next   = seg;
      end else begin
        axis_next = '0;
        case (ph)
          PH_INIT: begin
            state_next       = S_PUB;
            stat_next        = STAT_INIT;
            initialized_next = 1'b1;
          end
          PH_UPD0: begin
            ph_next  = PH_UPD1;
            seg_next = SEG_UPD1;
          end
          PH_UPD1: begin
            ph_next  = PH_FIX;
            seg_next = sts.singular ? SEG_SING : SEG_CORR;
          end
          PH_FIX: begin
            state_next = S_PUB;
            stat_next  = sts.singular ? STAT_SING : STAT_UPD;
          end
          PH_PRE0: begin
            ph_next  = PH_PRED;
            seg_next = initialized ? SEG_PRED : SEG_ZOUT;
          end
          default: begin
            state_next = S_PUB;
            stat_next  = STAT_PRED;
          end
        endcase
        pc_next = seg_next;
      end
    end
  end

  always_comb begin
    if (publish) out_valid_next = 1'b1;
    else if (!out_stall) out_valid_next = 1'b0;
    else out_valid_next = out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      ph          <= PH_INIT;
      pc          <= '0;
      seg         <= '0;
      axis        <= '0;
      stat        <= STAT_INIT;
      initialized <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      ph          <= ph_next;
      pc          <= pc_next;
      seg         <= seg_next;
      axis        <= axis_next;
      stat        <= stat_next;
      initialized <= initialized_next;
      out_valid   <= out_valid_next;
    end
  end

  always_comb begin
    ctl.load    = load;
    ctl.exec    = (state == S_EXEC);
    ctl.mul_wr  = (state == S_MULW);
    ctl.div_wr  = (state == S_DIVW) && sts.div_done;
    ctl.publish = publish;
    ctl.status  = stat;
    ctl.axis    = axis;
    ctl.ui      = ui;
  end

endmodule

// ===== sv/constant_velocity_kalman_tracker.sv =====
// Top level: 3-D constant-velocity Kalman tracker, controller plus datapath.
//
//   channel  signals                            direction  handshake
//   in       cmd, meas_x/y/z, time_or_delta     in         in_valid / in_stall
//   out      pos_x/y/z, vel_x/y/z, status,      out        out_valid / out_stall
//            clipped
//   cfg      cfg_index, cfg_data                in         cfg_valid / cfg_ready
//
// One item at a time. The length of a measurement update is set by the 48-step
// divider (15 divisions) and the single shared multiplier.
// Synchronous active-high reset; no clearing pass, the slot RAM is loaded by the
// first measurement. A finished result waits in the output register under out_stall.
module constant_velocity_kalman_tracker
  import cvkt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           cmd,
  input  logic [W-1:0]         meas_x,
  input  logic [W-1:0]         meas_y,
  input  logic [W-1:0]         meas_z,
  input  logic [W-1:0]         time_or_delta,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [W-1:0]         pos_x,
  output logic [W-1:0]         pos_y,
  output logic [W-1:0]         pos_z,
  output logic [W-1:0]         vel_x,
  output logic [W-1:0]         vel_y,
  output logic [W-1:0]         vel_z,
  output logic [1:0]           status,
  output logic                 clipped,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [W-1:0]         cfg_data
);

  ctl_t ctl;
  sts_t sts;

  assign cfg_ready = 1'b1;

  cvkt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl),
    .sts       (sts)
  );

  cvkt_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .sts           (sts),
    .cmd           (cmd),
    .meas_x        (meas_x),
    .meas_y        (meas_y),
    .meas_z        (meas_z),
    .time_or_delta (time_or_delta),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .pos_z         (pos_z),
    .vel_x         (vel_x),
    .vel_y         (vel_y),
    .vel_z         (vel_z),
    .status        (status),
    .clipped       (clipped)
  );

endmodule
